// File: rtl/core/tpi_pkg.sv
// Package for the three-plane intersection block.
// Holds default widths, fixed-point format constants and the threshold reset value.
// No dependencies.
package tpi_pkg;

  // Default field widths: normals Q2.14, offsets Q16.16.
  localparam int unsigned COEF_WIDTH_DEF   = 16;
  localparam int unsigned OFFSET_WIDTH_DEF = 32;

  // Result coordinates are Q16.16, 32 bits.
  localparam int unsigned PT_WIDTH   = 32;
  // Fraction bits of a normal; scales the numerator before the division.
  localparam int unsigned FRAC_SHIFT = 14;

  // Determinant threshold register, Q2.28.
  localparam int unsigned             THR_WIDTH = 30;
  localparam logic [THR_WIDTH-1:0]    THR_RESET = 30'd32;

endpackage

// File: rtl/core/tpi_in_if.sv
// Input channel of the three-plane intersection block: three planes per item.
// Depends on tpi_pkg for the default widths.
interface tpi_in_if
  import tpi_pkg::*;
#(
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COEF_WIDTH-1:0]   a_nx;
  logic signed [COEF_WIDTH-1:0]   a_ny;
  logic signed [COEF_WIDTH-1:0]   a_nz;
  logic signed [OFFSET_WIDTH-1:0] a_off;
  logic signed [COEF_WIDTH-1:0]   b_nx;
  logic signed [COEF_WIDTH-1:0]   b_ny;
  logic signed [COEF_WIDTH-1:0]   b_nz;
  logic signed [OFFSET_WIDTH-1:0] b_off;
  logic signed [COEF_WIDTH-1:0]   c_nx;
  logic signed [COEF_WIDTH-1:0]   c_ny;
  logic signed [COEF_WIDTH-1:0]   c_nz;
  logic signed [OFFSET_WIDTH-1:0] c_off;

  modport source (
    output valid, a_nx, a_ny, a_nz, a_off, b_nx, b_ny, b_nz, b_off,
           c_nx, c_ny, c_nz, c_off,
    input  ready
  );
  modport sink (
    input  valid, a_nx, a_ny, a_nz, a_off, b_nx, b_ny, b_nz, b_off,
           c_nx, c_ny, c_nz, c_off,
    output ready
  );
endinterface

// File: rtl/core/tpi_out_if.sv
// Output channel of the three-plane intersection block: one point per item.
// Depends on tpi_pkg for the coordinate width.
interface tpi_out_if
  import tpi_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [PT_WIDTH-1:0] pt_x;
  logic signed [PT_WIDTH-1:0] pt_y;
  logic signed [PT_WIDTH-1:0] pt_z;
  logic                       found;

  modport source (
    output valid, pt_x, pt_y, pt_z, found,
    input  ready
  );
  modport sink (
    input  valid, pt_x, pt_y, pt_z, found,
    output ready
  );
endinterface

// File: rtl/core/three_plane_intersection.sv
// Three-plane intersection: a pipelined solver from accepted item to result.
// Throughput one item per cycle while the output accepts; the 32-step pipelined restoring divider sets the depth.
// Each stage holds its item until the next stage frees, so a stall loses nothing.
// Reset clears all valid bits and loads the determinant threshold with 32.
// Depends on tpi_pkg, tpi_in_if and tpi_out_if.
module three_plane_intersection
  import tpi_pkg::*;
#(
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tpi_in_if.sink               item_i,
  tpi_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [THR_WIDTH-1:0] cfg_wdata_i
);

  // Derived widths: cross product, determinant, numerator.
  localparam int unsigned CW   = 2 * COEF_WIDTH + 1;
  localparam int unsigned DW   = CW + COEF_WIDTH + 2;
  localparam int unsigned NW   = CW + OFFSET_WIDTH + 2;
  localparam int unsigned DS   = PT_WIDTH;
  localparam int unsigned RSH  = PT_WIDTH - FRAC_SHIFT;
  localparam int unsigned TW   = THR_WIDTH + FRAC_SHIFT;
  localparam int unsigned CMPW = (DW > TW) ? DW : TW;
  localparam int unsigned OVW  = (NW > DW + RSH) ? NW : DW + RSH;
  // Stage map: 0 cross, 1 products, 2 sums, 3 prep, 4..3+DS divide, last output.
  localparam int unsigned NST  = DS + 5;
  localparam int unsigned OST  = NST - 1;

  localparam logic [PT_WIDTH:0]   POS_LIM = {2'b00, {(PT_WIDTH-1){1'b1}}};
  localparam logic [PT_WIDTH:0]   NEG_LIM = {2'b01, {(PT_WIDTH-1){1'b0}}};
  localparam logic [PT_WIDTH-1:0] POS_SAT = {1'b0, {(PT_WIDTH-1){1'b1}}};
  localparam logic [PT_WIDTH-1:0] NEG_SAT = {1'b1, {(PT_WIDTH-1){1'b0}}};

  // Threshold register.
  logic [THR_WIDTH-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Valid bits and the per-stage advance chain.
  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;

  assign adv[OST] = !vld_q[OST] || result_o.ready;
  for (genvar k = 0; k < OST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign item_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= item_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: the nine cross-product components.
  logic signed [CW-1:0]           cr_d [9];
  logic signed [CW-1:0]           cr_q [9];
  logic signed [COEF_WIDTH-1:0]   ax_q, ay_q, az_q;
  logic signed [OFFSET_WIDTH-1:0] ad_q, bd_q, cd_q;

  always_comb begin
    cr_d[0] = CW'(item_i.b_ny) * CW'(item_i.c_nz) - CW'(item_i.b_nz) * CW'(item_i.c_ny);
    cr_d[1] = CW'(item_i.b_nz) * CW'(item_i.c_nx) - CW'(item_i.b_nx) * CW'(item_i.c_nz);
    cr_d[2] = CW'(item_i.b_nx) * CW'(item_i.c_ny) - CW'(item_i.b_ny) * CW'(item_i.c_nx);
    cr_d[3] = CW'(item_i.c_ny) * CW'(item_i.a_nz) - CW'(item_i.c_nz) * CW'(item_i.a_ny);
    cr_d[4] = CW'(item_i.c_nz) * CW'(item_i.a_nx) - CW'(item_i.c_nx) * CW'(item_i.a_nz);
    cr_d[5] = CW'(item_i.c_nx) * CW'(item_i.a_ny) - CW'(item_i.c_ny) * CW'(item_i.a_nx);
    cr_d[6] = CW'(item_i.a_ny) * CW'(item_i.b_nz) - CW'(item_i.a_nz) * CW'(item_i.b_ny);
    cr_d[7] = CW'(item_i.a_nz) * CW'(item_i.b_nx) - CW'(item_i.a_nx) * CW'(item_i.b_nz);
    cr_d[8] = CW'(item_i.a_nx) * CW'(item_i.b_ny) - CW'(item_i.a_ny) * CW'(item_i.b_nx);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cr_q <= cr_d;
      ax_q <= item_i.a_nx;
      ay_q <= item_i.a_ny;
      az_q <= item_i.a_nz;
      ad_q <= item_i.a_off;
      bd_q <= item_i.b_off;
      cd_q <= item_i.c_off;
    end
  end

  // Stage 1: determinant and numerator products.
  logic signed [DW-1:0] dp_q [3];
  logic signed [NW-1:0] np_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      dp_q[0] <= DW'(cr_q[0]) * DW'(ax_q);
      dp_q[1] <= DW'(cr_q[1]) * DW'(ay_q);
      dp_q[2] <= DW'(cr_q[2]) * DW'(az_q);
      for (int l = 0; l < 3; l++) begin
        np_q[l][0] <= NW'(cr_q[l])   * NW'(ad_q);
        np_q[l][1] <= NW'(cr_q[l+3]) * NW'(bd_q);
        np_q[l][2] <= NW'(cr_q[l+6]) * NW'(cd_q);
      end
    end
  end

  // Stage 2: sums.
  logic signed [DW-1:0] det_q;
  logic signed [NW-1:0] num_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      det_q <= dp_q[0] + dp_q[1] + dp_q[2];
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= np_q[l][0] + np_q[l][1] + np_q[l][2];
      end
    end
  end

  // Divider state; index 0 is the prep stage, index i the result of step i.
  logic [DW-1:0]       dmag_q [DS+1];
  logic                fnd_q  [DS+1];
  logic [DW-1:0]       rem_q  [DS+1][3];
  logic [PT_WIDTH-1:0] lo_q   [DS+1][3];
  logic [PT_WIDTH-1:0] quo_q  [DS+1][3];
  logic                neg_q  [DS+1][3];
  logic                ovf_q  [DS+1][3];

  // Stage 3: magnitudes, degenerate test, overflow test and divider seed.
  logic [DW-1:0]       dmag_d;
  logic                fnd_d;
  logic [NW-1:0]       nmag_d [3];
  logic [OVW-1:0]      nx_d   [3];
  logic [DW-1:0]       rem0_d [3];
  logic [PT_WIDTH-1:0] lo0_d  [3];
  logic                neg0_d [3];
  logic                ovf0_d [3];

  always_comb begin
    dmag_d = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    fnd_d  = (dmag_d != '0) && !(CMPW'(dmag_d) < CMPW'({thr_q, {FRAC_SHIFT{1'b0}}}));
    for (int l = 0; l < 3; l++) begin
      nmag_d[l] = num_q[l][NW-1] ? NW'(-num_q[l]) : NW'(num_q[l]);
      nx_d[l]   = OVW'(nmag_d[l]);
      ovf0_d[l] = nx_d[l] >= (OVW'(dmag_d) << RSH);
      rem0_d[l] = DW'(nx_d[l] >> RSH);
      lo0_d[l]  = {nmag_d[l][RSH-1:0], {FRAC_SHIFT{1'b0}}};
      // The result is -num/det, negative when both signs agree.
      neg0_d[l] = num_q[l][NW-1] == det_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      dmag_q[0] <= dmag_d;
      fnd_q[0]  <= fnd_d;
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= rem0_d[l];
        lo_q[0][l]  <= lo0_d[l];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg0_d[l];
        ovf_q[0][l] <= ovf0_d[l];
      end
    end
  end

  // Restoring divider: one quotient bit per stage for each of the three lanes.
  for (genvar i = 1; i <= DS; i++) begin : g_div
    logic [DW:0] trial [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_q[i-1][l], lo_q[i-1][l][PT_WIDTH-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[3+i]) begin
        dmag_q[i] <= dmag_q[i-1];
        fnd_q[i]  <= fnd_q[i-1];
        for (int l = 0; l < 3; l++) begin
          lo_q[i][l]  <= lo_q[i-1][l] << 1;
          neg_q[i][l] <= neg_q[i-1][l];
          ovf_q[i][l] <= ovf_q[i-1][l];
          if (trial[l] >= {1'b0, dmag_q[i-1]}) begin
            rem_q[i][l] <= DW'(trial[l] - {1'b0, dmag_q[i-1]});
            quo_q[i][l] <= {quo_q[i-1][l][PT_WIDTH-2:0], 1'b1};
          end else begin
            rem_q[i][l] <= DW'(trial[l]);
            quo_q[i][l] <= {quo_q[i-1][l][PT_WIDTH-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output stage: round half away from zero, apply sign, saturate; zero when degenerate.
  logic                found_q;
  logic [PT_WIDTH-1:0] pt_d [3];
  logic [PT_WIDTH-1:0] pt_q [3];
  logic                rnd  [3];
  logic [PT_WIDTH:0]   q33  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = {rem_q[DS][l], 1'b0} >= {1'b0, dmag_q[DS]};
      q33[l] = {1'b0, quo_q[DS][l]} + (PT_WIDTH+1)'(rnd[l]);
      if (!fnd_q[DS]) begin
        pt_d[l] = '0;
      end else if (neg_q[DS][l]) begin
        pt_d[l] = (ovf_q[DS][l] || q33[l] > NEG_LIM) ? NEG_SAT : PT_WIDTH'(-q33[l]);
      end else begin
        pt_d[l] = (ovf_q[DS][l] || q33[l] > POS_LIM) ? POS_SAT : q33[l][PT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OST]) begin
      pt_q    <= pt_d;
      found_q <= fnd_q[DS];
    end
  end

  assign result_o.valid = vld_q[OST];
  assign result_o.pt_x  = pt_q[0];
  assign result_o.pt_y  = pt_q[1];
  assign result_o.pt_z  = pt_q[2];
  assign result_o.found = found_q;

endmodule

// File: verif/three_plane_intersection_test.sv
// Self-checking testbench for the three-plane intersection block.
// Drives plane triples through tpi_in_if and checks each point against an exact predictor.
// Depends on tpi_pkg, tpi_in_if, tpi_out_if and three_plane_intersection.
`timescale 1ns / 1ps

module three_plane_intersection_test;
  import tpi_pkg::*;

  localparam int unsigned CW = COEF_WIDTH_DEF;
  localparam int unsigned OW = OFFSET_WIDTH_DEF;
  localparam int LATENCY = 37;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic signed [CW-1:0] a_nx, a_ny, a_nz;
    logic signed [OW-1:0] a_off;
    logic signed [CW-1:0] b_nx, b_ny, b_nz;
    logic signed [OW-1:0] b_off;
    logic signed [CW-1:0] c_nx, c_ny, c_nz;
    logic signed [OW-1:0] c_off;
  } planes_t;

  typedef struct packed {
    logic signed [PT_WIDTH-1:0] pt_x, pt_y, pt_z;
    logic                       found;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THR_WIDTH-1:0] cfg_wdata_i = '0;

  tpi_in_if  item_if ();
  tpi_out_if result_if ();

  three_plane_intersection i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if.sink),
    .result_o    (result_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  planes_t pending_planes[$];
  point_t  expected_points[$];
  logic [THR_WIDTH-1:0] threshold_model = THR_RESET;
  int  mismatches = 0;
  bit  stimulus_done = 1'b0;
  bit  hold_result = 1'b0;
  bit  in_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  // Divides a scaled numerator by |det|, rounds half away and saturates to Q16.16.
  function automatic logic signed [31:0] solve_coord(logic signed [127:0] num,
                                                     logic signed [127:0] det);
    logic [127:0] n_mag, d_mag, q, r;
    logic neg;
    neg = (num < 0) == (det < 0);
    n_mag = (num < 0) ? -num : num;
    d_mag = (det < 0) ? -det : det;
    n_mag = n_mag << FRAC_SHIFT;
    q = n_mag / d_mag;
    r = n_mag % d_mag;
    if ((r << 1) >= d_mag) q = q + 1;
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return $signed(q[31:0]);
  endfunction

  // Cramer's rule on the three planes with the degenerate threshold test.
  function automatic point_t intersect_planes(planes_t p);
    logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz, ad, bd, cd;
    logic signed [127:0] bc[3], ca[3], ab[3], det, mag, num;
    point_t res;
    ax = p.a_nx; ay = p.a_ny; az = p.a_nz; ad = p.a_off;
    bx = p.b_nx; by = p.b_ny; bz = p.b_nz; bd = p.b_off;
    cx = p.c_nx; cy = p.c_ny; cz = p.c_nz; cd = p.c_off;
    bc[0] = by*cz - bz*cy; bc[1] = bz*cx - bx*cz; bc[2] = bx*cy - by*cx;
    ca[0] = cy*az - cz*ay; ca[1] = cz*ax - cx*az; ca[2] = cx*ay - cy*ax;
    ab[0] = ay*bz - az*by; ab[1] = az*bx - ax*bz; ab[2] = ax*by - ay*bx;
    det = bc[0]*ax + bc[1]*ay + bc[2]*az;
    mag = (det < 0) ? -det : det;
    res = '0;
    if (det == 0 || mag < ($signed({98'd0, threshold_model}) <<< FRAC_SHIFT)) return res;
    num = bc[0]*ad + ca[0]*bd + ab[0]*cd;
    res.pt_x = solve_coord(num, det);
    num = bc[1]*ad + ca[1]*bd + ab[1]*cd;
    res.pt_y = solve_coord(num, det);
    num = bc[2]*ad + ca[2]*bd + ab[2]*cd;
    res.pt_z = solve_coord(num, det);
    res.found = 1'b1;
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh4000;
      3: return 16'shC000;
      4: return 16'(32'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [OW-1:0] rand_off();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2000)) - 1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic planes_t rand_planes();
    planes_t p;
    p.a_nx = rand_coef(); p.a_ny = rand_coef(); p.a_nz = rand_coef(); p.a_off = rand_off();
    p.b_nx = rand_coef(); p.b_ny = rand_coef(); p.b_nz = rand_coef(); p.b_off = rand_off();
    p.c_nx = rand_coef(); p.c_ny = rand_coef(); p.c_nz = rand_coef(); p.c_off = rand_off();
    // Now and then make the third plane parallel to the first.
    if ($urandom_range(0, 9) == 0) begin
      p.c_nx = p.a_nx; p.c_ny = p.a_ny; p.c_nz = p.a_nz;
    end
    return p;
  endfunction

  function automatic planes_t axis_planes(logic signed [CW-1:0] s, logic signed [OW-1:0] d);
    planes_t p;
    p = '0;
    p.a_nx = s; p.b_ny = s; p.c_nz = s;
    p.a_off = d; p.b_off = -d; p.c_off = d;
    return p;
  endfunction

  task automatic write_threshold(logic [THR_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    threshold_model = value;
  endtask

  task automatic drain_pipeline();
    while (pending_planes.size() != 0 || expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Remembers whether the offered item was taken at the last rising edge.
  always @(posedge clk_i) in_taken <= item_if.valid && item_if.ready;

  // Driver: offers queued items in bursts with random gaps.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.a_nx <= '0; item_if.a_ny <= '0; item_if.a_nz <= '0; item_if.a_off <= '0;
      item_if.b_nx <= '0; item_if.b_ny <= '0; item_if.b_nz <= '0; item_if.b_off <= '0;
      item_if.c_nx <= '0; item_if.c_ny <= '0; item_if.c_nz <= '0; item_if.c_off <= '0;
    end else if (!item_if.valid || in_taken) begin
      if (item_if.valid) void'(pending_planes.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_if.valid <= 1'b0;
      end else if (pending_planes.size() != 0) begin
        item_if.valid <= 1'b1;
        {item_if.a_nx, item_if.a_ny, item_if.a_nz, item_if.a_off,
         item_if.b_nx, item_if.b_ny, item_if.b_nz, item_if.b_off,
         item_if.c_nx, item_if.c_ny, item_if.c_nz, item_if.c_off} <= pending_planes[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on its own pattern, or holds off fully during a pressure stretch.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_if.ready <= 1'b0;
    else if (hold_result) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(0, 3) != 0) || (($urandom() & 32'h3F) < 8);
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready)
        expected_points.push_back(intersect_planes({item_if.a_nx, item_if.a_ny,
          item_if.a_nz, item_if.a_off, item_if.b_nx, item_if.b_ny, item_if.b_nz,
          item_if.b_off, item_if.c_nx, item_if.c_ny, item_if.c_nz, item_if.c_off}));
      if (result_if.valid && result_if.ready) begin
        got = {result_if.pt_x, result_if.pt_y, result_if.pt_z, result_if.found};
        if (expected_points.size() == 0) begin
          $error("unexpected point x=%0d y=%0d z=%0d", got.pt_x, got.pt_y, got.pt_z);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got.pt_x !== want.pt_x) begin
            $error("pt_x expected %0d actual %0d", want.pt_x, got.pt_x); mismatches++;
          end
          if (got.pt_y !== want.pt_y) begin
            $error("pt_y expected %0d actual %0d", want.pt_y, got.pt_y); mismatches++;
          end
          if (got.pt_z !== want.pt_z) begin
            $error("pt_z expected %0d actual %0d", want.pt_z, got.pt_z); mismatches++;
          end
          if (got.found !== want.found) begin
            $error("found expected %0b actual %0b", want.found, got.found); mismatches++;
          end
        end
      end
    end
  end

  // Directed planes, a pressure phase, then random phases across several thresholds.
  initial begin
    logic [THR_WIDTH-1:0] thresholds[4];
    planes_t p;
    thresholds = '{30'd0, 30'h3FFF_FFFF, 30'd1, 30'($urandom_range(0, 1 << 20))};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    pending_planes.push_back(axis_planes(16'sh4000, 32'sh0001_0000));
    pending_planes.push_back(axis_planes(16'sh4000, 32'sh7FFF_FFFF));
    pending_planes.push_back(axis_planes(16'sh4000, 32'sh8000_0000));
    pending_planes.push_back(axis_planes(16'sh0001, 32'sh7FFF_FFFF));
    pending_planes.push_back(axis_planes(16'sh8000, 32'sh8000_0000));
    pending_planes.push_back(axis_planes(16'sh7FFF, 32'sh0000_0001));
    pending_planes.push_back(axis_planes(16'shFFFF, 32'sh0000_0003));
    pending_planes.push_back(axis_planes(16'sh0000, 32'sh1234_5678));
    pending_planes.push_back(axis_planes(16'sh0004, 32'sh0000_0100));
    pending_planes.push_back(axis_planes(16'sh0003, 32'sh0000_0100));
    p = axis_planes(16'sh4000, 32'sh0000_8000);
    p.c_nx = p.a_nx; p.c_nz = 0;
    pending_planes.push_back(p);
    p = '1;
    pending_planes.push_back(p);
    drain_pipeline();
    // Pressure: stop the receiver for a long stretch while items keep coming.
    hold_result = 1'b1;
    repeat (60) pending_planes.push_back(rand_planes());
    repeat (150) @(posedge clk_i);
    hold_result = 1'b0;
    drain_pipeline();
    foreach (thresholds[t]) begin
      write_threshold(thresholds[t]);
      repeat (RANDOM_ITEMS / 4) pending_planes.push_back(rand_planes());
      pending_planes.push_back(axis_planes(16'sh0001, 32'sh0000_0001));
      pending_planes.push_back(axis_planes(16'sh0800, 32'sh0000_0001));
      drain_pipeline();
    end
    write_threshold(THR_RESET);
    repeat (20) pending_planes.push_back(rand_planes());
    drain_pipeline();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tpi_pkg.sv
rtl/core/tpi_in_if.sv
rtl/core/tpi_out_if.sv
rtl/core/three_plane_intersection.sv
verif/three_plane_intersection_test.sv
